// ===== rtl/banked_register_file_mode_switch_macros.svh =====
// assertion macros used by the register file checker
`ifndef BANKED_REGISTER_FILE_MODE_SWITCH_MACROS_SVH
`define BANKED_REGISTER_FILE_MODE_SWITCH_MACROS_SVH

// property checked outside reset
`define BRF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define BRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/brf_pkg.sv =====
// types, codes and helpers for the banked register file
package brf_pkg;

  localparam int unsigned NUM_REGS  = 16;
  localparam int unsigned NUM_BANKS = 6;
  localparam int unsigned NUM_HIGH  = 5;
  localparam int unsigned HIGH_BASE = 8;

  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_LR = 4'd14;

  localparam logic [2:0] CMD_READ_REG   = 3'd0;
  localparam logic [2:0] CMD_WRITE_REG  = 3'd1;
  localparam logic [2:0] CMD_READ_CPSR  = 3'd2;
  localparam logic [2:0] CMD_WRITE_CPSR = 3'd3;
  localparam logic [2:0] CMD_READ_SPSR  = 3'd4;
  localparam logic [2:0] CMD_WRITE_SPSR = 3'd5;
  // spare codes: no state change, read data zero
  localparam logic [2:0] CMD_SPARE_LO   = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI   = 3'd7;

  localparam logic [4:0] MODE_USER = 5'h10;
  localparam logic [4:0] MODE_FIQ  = 5'h11;
  localparam logic [4:0] MODE_IRQ  = 5'h12;
  localparam logic [4:0] MODE_SVC  = 5'h13;
  localparam logic [4:0] MODE_ABT  = 5'h17;
  localparam logic [4:0] MODE_UND  = 5'h1B;
  localparam logic [4:0] MODE_SYS  = 5'h1F;

  localparam int unsigned THUMB_BIT    = 5;
  localparam logic [31:0] RESET_STATUS = 32'h0000_00D3;

  typedef logic [2:0] bank_t;

  localparam bank_t BANK_USER = 3'd0;
  localparam bank_t BANK_FIQ  = 3'd1;
  localparam bank_t BANK_IRQ  = 3'd2;
  localparam bank_t BANK_SVC  = 3'd3;
  localparam bank_t BANK_ABT  = 3'd4;
  localparam bank_t BANK_UND  = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  reg_index;
    logic [31:0] write_value;
  } brf_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [4:0]  mode_bits;
    logic        thumb_flag;
  } brf_rsp_t;

  // user, system and unknown codes all land in bank 0
  function automatic bank_t bank_of(logic [4:0] mode);
    bank_t b;
    unique case (mode)
      MODE_FIQ: b = BANK_FIQ;
      MODE_IRQ: b = BANK_IRQ;
      MODE_SVC: b = BANK_SVC;
      MODE_ABT: b = BANK_ABT;
      MODE_UND: b = BANK_UND;
      default:  b = BANK_USER;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/banked_register_file_mode_switch.sv =====
// top level: banked register file with mode switching on cpsr writes
// Each request (read or write a register, the CPSR or the current mode's SPSR) is handled
// in a single pass: the command is decoded against the register state, the state is updated
// and the response is registered at the same clock edge, so one transaction is taken every
// cycle while req_ready is high. A CPSR write that changes the mode field
// swaps r13/r14 with the banked copies, and r8-r12 as well on entry to or exit from FIQ,
// in that same cycle. A two-entry output stage (response register plus skid register) keeps
// requests flowing while a response waits; req_ready drops only when both are full. In user,
// system or an unknown mode an SPSR read returns the CPSR and an SPSR write is dropped.
module banked_register_file_mode_switch (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  brf_pkg::brf_req_t req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output brf_pkg::brf_rsp_t rsp
);
  import brf_pkg::*;

  logic [31:0] visible_regs [NUM_REGS];
  logic [31:0] status_word;
  logic [31:0] stack_ptr_bank [NUM_BANKS];
  logic [31:0] link_reg_bank [NUM_BANKS];
  logic [31:0] saved_status_bank [NUM_BANKS];
  logic [31:0] fast_irq_high_regs [NUM_HIGH];
  logic [31:0] user_high_regs [NUM_HIGH];

  brf_rsp_t skid;
  logic     skid_valid;

  logic        req_fire;
  logic        rsp_fire;
  logic [4:0]  cur_mode;
  logic [4:0]  new_mode;
  bank_t       old_bank;
  bank_t       new_bank;
  logic        mode_change;
  logic        leave_fiq;
  logic        enter_fiq;
  logic [31:0] status_next;
  brf_rsp_t    result;

  assign req_ready = !skid_valid;
  assign req_fire  = req_valid && req_ready;
  assign rsp_fire  = rsp_valid && rsp_ready;

  always_comb begin
    cur_mode    = status_word[4:0];
    new_mode    = req.write_value[4:0];
    old_bank    = bank_of(cur_mode);
    new_bank    = bank_of(new_mode);
    mode_change = (req.cmd == CMD_WRITE_CPSR) && (cur_mode != new_mode);
    leave_fiq   = mode_change && (cur_mode == MODE_FIQ);
    enter_fiq   = mode_change && (new_mode == MODE_FIQ);
    status_next = (req.cmd == CMD_WRITE_CPSR) ? req.write_value : status_word;

    result.read_data = '0;
    case (req.cmd)
      CMD_READ_REG:  result.read_data = visible_regs[req.reg_index];
      CMD_READ_CPSR: result.read_data = status_word;
      CMD_READ_SPSR: result.read_data = (old_bank == BANK_USER) ? status_word
                                                                : saved_status_bank[old_bank];
      default:       result.read_data = '0;
    endcase
    result.mode_bits  = status_next[4:0];
    result.thumb_flag = status_next[THUMB_BIT];
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      status_word <= RESET_STATUS;
      for (int i = 0; i < NUM_REGS; i++) visible_regs[i] <= '0;
      for (int i = 0; i < NUM_BANKS; i++) begin
        stack_ptr_bank[i]    <= '0;
        link_reg_bank[i]     <= '0;
        saved_status_bank[i] <= '0;
      end
      for (int i = 0; i < NUM_HIGH; i++) begin
        fast_irq_high_regs[i] <= '0;
        user_high_regs[i]     <= '0;
      end
    end else if (req_fire) begin
      case (req.cmd)
        CMD_WRITE_REG: begin
          visible_regs[req.reg_index] <= req.write_value;
        end
        CMD_WRITE_CPSR: begin
          status_word <= req.write_value;
          if (mode_change) begin
            stack_ptr_bank[old_bank] <= visible_regs[REG_SP];
            link_reg_bank[old_bank]  <= visible_regs[REG_LR];
            // same bank under another code: sp and lr come back unchanged
            if (old_bank != new_bank) begin
              visible_regs[REG_SP] <= stack_ptr_bank[new_bank];
              visible_regs[REG_LR] <= link_reg_bank[new_bank];
            end
          end
          for (int i = 0; i < NUM_HIGH; i++) begin
            if (leave_fiq) begin
              fast_irq_high_regs[i]              <= visible_regs[4'(HIGH_BASE + i)];
              visible_regs[4'(HIGH_BASE + i)]    <= user_high_regs[i];
            end else if (enter_fiq) begin
              user_high_regs[i]                  <= visible_regs[4'(HIGH_BASE + i)];
              visible_regs[4'(HIGH_BASE + i)]    <= fast_irq_high_regs[i];
            end
          end
        end
        CMD_WRITE_SPSR: begin
          if (old_bank != BANK_USER) saved_status_bank[old_bank] <= req.write_value;
        end
        default: ;
      endcase
    end
  end

  // output stage control: response register backed by one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (rsp_fire) begin
      rsp_valid  <= skid_valid || req_fire;
      skid_valid <= 1'b0;
    end else if (rsp_valid) begin
      if (req_fire) skid_valid <= 1'b1;
    end else begin
      rsp_valid <= req_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_fire) begin
      rsp <= skid_valid ? skid : result;
    end else if (rsp_valid) begin
      if (req_fire) skid <= result;
    end else if (req_fire) begin
      rsp <= result;
    end
  end

endmodule

// ===== rtl/brf_checker.sv =====
// port-level checker for the banked register file, bound to the top level
`include "banked_register_file_mode_switch_macros.svh"

module brf_checker (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input brf_pkg::brf_rsp_t rsp
);

  `BRF_ASSERT_ALWAYS(a_rst_clears_rsp, clk, rst |=> !rsp_valid, "response valid after reset")

  `BRF_ASSERT(a_accept_gives_rsp, clk, rst, req_valid && req_ready |=> rsp_valid,
              "accepted transaction produced no response")

  `BRF_ASSERT(a_empty_is_ready, clk, rst, !rsp_valid |-> req_ready,
              "request blocked with empty output stage")

  `BRF_ASSERT(a_skid_fills, clk, rst,
              rsp_valid && !rsp_ready && req_valid && req_ready |=> !req_ready,
              "request taken with both output entries full")

  `BRF_ASSERT(a_rsp_holds, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp),
              "stalled response changed")

endmodule

bind banked_register_file_mode_switch brf_checker u_brf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
